/* hw/rtl/ocmc_pkg.sv */
// shared types, constants and state codes for the center-of-mass clustering block
`timescale 1ns / 1ps
`default_nettype none
package ocmc_pkg;

  localparam int NCL       = 8;                  // cluster slots
  localparam int CH        = 4;                  // sample channels
  localparam int FB        = 8;                  // fraction bits of a center
  localparam int SW        = 8;                  // sample width
  localparam int SLW       = 3;                  // slot / rank index width
  localparam int CW        = SW + FB;            // center channel width
  localparam int MW        = 16;                 // mass width
  localparam int TW        = 16;                 // idle timer width
  localparam int DW        = 35;                 // squared distance width
  localparam int PW        = MW + DW;            // cross product width
  localparam int CNTW      = 4;                  // live / removed count width
  localparam int THRW      = 32;                 // force threshold width
  localparam int DLO       = 18;                 // low split of distance for threshold
  localparam int NUMW      = 2 * CW + 1;         // divide numerator width
  localparam int DENW      = MW + 1;             // divide denominator width
  localparam int DIV_STEPS = NUMW;               // one quotient bit per step
  localparam int EPS       = ((1 << (2 * FB)) + 500) / 1000;
  localparam logic [MW-1:0] MASS_MAX = {MW{1'b1}};

  // configuration register indexes
  localparam logic CFG_TIMER = 1'b0;
  localparam logic CFG_THR   = 1'b1;

  typedef logic [CW-1:0] ch_t;
  typedef ch_t [CH-1:0] ctr_t;
  typedef logic [NCL-1:0][SLW-1:0] rank_vec_t;

  // best candidate moving down the chain of cells
  typedef struct packed {
    logic           found;
    logic [MW-1:0]  mass;
    logic [DW-1:0]  d;
    logic [SLW-1:0] rank;
    logic [SLW-1:0] slot;
  } tok_t;

  // command broadcast from the controller to every cell
  typedef struct packed {
    logic           tick;
    logic           create;
    logic           update;
    logic [SLW-1:0] slot;
    ctr_t           cval;
    logic [TW-1:0]  reload;
  } cmd_t;

  // contents of one cell seen by the controller
  typedef struct packed {
    logic           valid;
    logic [MW-1:0]  mass;
    logic [TW-1:0]  timer;
    logic [SLW-1:0] rank;
    ctr_t           center;
  } stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK,
    ST_DIST,
    ST_SCAN,
    ST_THR1,
    ST_THR2,
    ST_PREP,
    ST_DIV,
    ST_APPLY,
    ST_FIN
  } state_t;

endpackage
`default_nettype wire

/* hw/rtl/ocmc_cell.sv */
// one cluster cell: holds a cluster, computes its distance, forwards the best candidate
`timescale 1ns / 1ps
`default_nettype none
module ocmc_cell (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [ocmc_pkg::SLW-1:0]   idx,
  input  wire ocmc_pkg::cmd_t             cmd,
  input  wire ocmc_pkg::ctr_t             smp,
  input  wire logic [ocmc_pkg::NCL-1:0]   gone,
  input  wire ocmc_pkg::rank_vec_t        ranks,
  input  wire ocmc_pkg::tok_t             tok_in,
  output ocmc_pkg::tok_t                  tok_out,
  output ocmc_pkg::stat_t                 stat
);

  logic                     valid_r;
  ocmc_pkg::ctr_t           center_r;
  logic [ocmc_pkg::MW-1:0]  mass_r;
  logic [ocmc_pkg::TW-1:0]  timer_r;
  logic [ocmc_pkg::SLW-1:0] rank_r;
  logic [ocmc_pkg::DW-1:0]  d_r, d_nxt;
  ocmc_pkg::tok_t           tok_r, tok_nxt;
  logic [ocmc_pkg::PW-1:0]  lhs, rhs;
  logic                     take;
  logic [ocmc_pkg::CNTW-1:0] less;
  logic                     me;

  // squared distance to the broadcast sample plus epsilon
  always_comb begin
    logic [ocmc_pkg::CW-1:0] diff;
    logic [ocmc_pkg::DW-1:0] acc;
    acc = ocmc_pkg::DW'(ocmc_pkg::EPS);
    for (int c = 0; c < ocmc_pkg::CH; c++) begin
      diff = (smp[c] >= center_r[c]) ? smp[c] - center_r[c] : center_r[c] - smp[c];
      acc  = acc + ocmc_pkg::DW'(32'(diff) * 32'(diff));
    end
    d_nxt = acc;
  end

  // force compare by cross multiplication, ties to the newer cluster
  assign lhs  = ocmc_pkg::PW'(mass_r) * ocmc_pkg::PW'(tok_in.d);
  assign rhs  = ocmc_pkg::PW'(tok_in.mass) * ocmc_pkg::PW'(d_r);
  assign take = valid_r &&
                (!tok_in.found || (lhs > rhs) || ((lhs == rhs) && (rank_r < tok_in.rank)));

  always_comb begin
    tok_nxt = tok_in;
    if (take) begin
      tok_nxt.found = 1'b1;
      tok_nxt.mass  = mass_r;
      tok_nxt.d     = d_r;
      tok_nxt.rank  = rank_r;
      tok_nxt.slot  = idx;
    end
  end

  // newer clusters removed by a tick shift this rank down
  always_comb begin
    less = '0;
    for (int j = 0; j < ocmc_pkg::NCL; j++) begin
      if (gone[j] && (ranks[j] < rank_r)) less = less + 1'b1;
    end
  end

  assign me = (cmd.slot == idx);

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.tick) begin
      if (valid_r && (timer_r == '0)) valid_r <= 1'b0;
    end else if (cmd.create && me) begin
      valid_r <= 1'b1;
    end
  end

  // cluster payload, distance and candidate registers
  always_ff @(posedge clk) begin
    d_r   <= d_nxt;
    tok_r <= tok_nxt;
    if (cmd.tick) begin
      if (valid_r && (timer_r != '0)) begin
        timer_r <= timer_r - 1'b1;
        rank_r  <= rank_r - ocmc_pkg::SLW'(less);
      end
    end else if (cmd.create) begin
      if (me) begin
        center_r <= cmd.cval;
        mass_r   <= ocmc_pkg::MW'(1);
        timer_r  <= cmd.reload;
        rank_r   <= '0;
      end else if (valid_r) begin
        rank_r <= rank_r + 1'b1;
      end
    end else if (cmd.update && me) begin
      center_r <= cmd.cval;
      if (mass_r != ocmc_pkg::MASS_MAX) mass_r <= mass_r + 1'b1;
      timer_r  <= cmd.reload;
    end
  end

  assign tok_out      = tok_r;
  assign stat.valid   = valid_r;
  assign stat.mass    = mass_r;
  assign stat.timer   = timer_r;
  assign stat.rank    = rank_r;
  assign stat.center  = center_r;

endmodule
`default_nettype wire

/* hw/rtl/ocmc_div_lane.sv */
// one lane of the restoring divider for the center update, one quotient bit a cycle while step is high
`timescale 1ns / 1ps
`default_nettype none
module ocmc_div_lane (
  input  wire logic                      clk,
  input  wire logic                      load,
  input  wire logic                      step,
  input  wire logic [ocmc_pkg::NUMW-1:0] num,
  input  wire logic [ocmc_pkg::DENW-1:0] den,
  output logic      [ocmc_pkg::CW-1:0]   quot
);

  logic [ocmc_pkg::NUMW-1:0] num_r;
  logic [ocmc_pkg::DENW-1:0] den_r;
  logic [ocmc_pkg::DENW-1:0] rem_r;
  logic [ocmc_pkg::CW-1:0]   q_r;
  logic [ocmc_pkg::DENW:0]   rem_sh;
  logic                      ge;

  assign rem_sh = {rem_r, num_r[ocmc_pkg::NUMW-1]};
  assign ge     = (rem_sh >= {1'b0, den_r});

  // shift in one numerator bit, subtract when it fits
  always_ff @(posedge clk) begin
    if (load) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      q_r   <= '0;
    end else if (step) begin
      num_r <= {num_r[ocmc_pkg::NUMW-2:0], 1'b0};
      rem_r <= ge ? ocmc_pkg::DENW'(rem_sh - {1'b0, den_r}) : ocmc_pkg::DENW'(rem_sh);
      q_r   <= {q_r[ocmc_pkg::CW-2:0], ge};
    end
  end

  assign quot = q_r;

endmodule
`default_nettype wire

/* hw/rtl/online_center_of_mass_clustering.sv */
// top level: controller, chain of cluster cells and center update dividers
// flow: a tick goes from accept through the tick state to the result; a sample computes its
// distances, passes the candidate down the chain of cells and makes the threshold test, then
// creates a cluster, is dropped, or runs the dividers before it updates the winning cluster
// throughput: one item at a time, next item accepted the cycle after the result is registered
// reset: synchronous active low, clears all valid bits and loads the configuration and control registers to defaults
`timescale 1ns / 1ps
`default_nettype none
module online_center_of_mass_clustering (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // sample_ch0, sample_ch1, sample_ch2, sample_ch3
  input  wire logic        in_tuser,   // kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // created, dropped, winner_slot, removed_count, live_count
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  ocmc_pkg::state_t state_r, state_nxt;

  logic [ocmc_pkg::TW-1:0]   reload_r;
  logic [ocmc_pkg::THRW-1:0] thr_r;
  logic                      kind_r;
  ocmc_pkg::ctr_t            smp_r;
  logic [5:0]                cnt_r, cnt_nxt;
  ocmc_pkg::tok_t            win_r;
  logic [ocmc_pkg::THRW+ocmc_pkg::DLO-1:0]           p0_r;
  logic [ocmc_pkg::THRW+ocmc_pkg::DW-ocmc_pkg::DLO-1:0] p1_r;
  logic                      created_r, dropped_r, upd_r;
  logic [ocmc_pkg::SLW-1:0]  slot_r;
  logic [ocmc_pkg::CNTW-1:0] removed_r;
  logic                      out_valid_r;
  logic [15:0]               out_data_r;

  ocmc_pkg::cmd_t            cmd;
  ocmc_pkg::stat_t           st [ocmc_pkg::NCL];
  ocmc_pkg::tok_t            tok [ocmc_pkg::NCL];
  ocmc_pkg::tok_t            tok_zero;
  logic [ocmc_pkg::NCL-1:0]  valid_vec, gone_vec;
  ocmc_pkg::rank_vec_t       rank_vec;
  logic [ocmc_pkg::CNTW-1:0] live_cnt, gone_cnt;
  logic [ocmc_pkg::SLW-1:0]  free_slot;
  logic                      full;
  logic                      make_new;
  logic                      lane_load, lane_step;
  ocmc_pkg::ctr_t            quot;
  logic [ocmc_pkg::DENW-1:0] den;
  logic                      accept, out_free;

  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign tok_zero = '0;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reload_r <= ocmc_pkg::TW'(100);
      thr_r    <= ocmc_pkg::THRW'(65536);
    end else if (cfg_we) begin
      case (cfg_index)
        ocmc_pkg::CFG_TIMER: reload_r <= cfg_wdata[ocmc_pkg::TW-1:0];
        ocmc_pkg::CFG_THR:   thr_r    <= cfg_wdata;
        default:             ;
      endcase
    end
  end

  // chain of cells
  for (genvar k = 0; k < ocmc_pkg::NCL; k++) begin : g_cell
    ocmc_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .idx     (ocmc_pkg::SLW'(k)),
      .cmd     (cmd),
      .smp     (smp_r),
      .gone    (gone_vec),
      .ranks   (rank_vec),
      .tok_in  ((k == 0) ? tok_zero : tok[(k == 0) ? 0 : k - 1]),
      .tok_out (tok[k]),
      .stat    (st[k])
    );
    assign valid_vec[k] = st[k].valid;
    assign gone_vec[k]  = st[k].valid && (st[k].timer == '0);
    assign rank_vec[k]  = st[k].rank;
  end

  // counts and lowest free slot
  always_comb begin
    live_cnt  = '0;
    gone_cnt  = '0;
    free_slot = '0;
    for (int k = 0; k < ocmc_pkg::NCL; k++) begin
      if (valid_vec[k]) live_cnt = live_cnt + 1'b1;
      if (gone_vec[k])  gone_cnt = gone_cnt + 1'b1;
    end
    for (int k = ocmc_pkg::NCL - 1; k >= 0; k--) begin
      if (!valid_vec[k]) free_slot = ocmc_pkg::SLW'(k);
    end
  end
  assign full = &valid_vec;

  // threshold test: no candidate found, or mass * 2^(2F+16) below threshold * distance
  always_comb begin
    logic [ocmc_pkg::THRW+ocmc_pkg::DW-1:0] rhs;
    logic [ocmc_pkg::THRW+ocmc_pkg::DW-1:0] lhs;
    rhs = (ocmc_pkg::THRW+ocmc_pkg::DW)'(p0_r) +
          ((ocmc_pkg::THRW+ocmc_pkg::DW)'(p1_r) << ocmc_pkg::DLO);
    lhs = (ocmc_pkg::THRW+ocmc_pkg::DW)'(win_r.mass) << (2 * ocmc_pkg::FB + 16);
    make_new = !win_r.found || (lhs < rhs);
  end

  // center update dividers, one per channel
  assign den = ocmc_pkg::DENW'(win_r.mass) + 1'b1;
  for (genvar c = 0; c < ocmc_pkg::CH; c++) begin : g_div
    logic [ocmc_pkg::NUMW-1:0] num;
    assign num = ocmc_pkg::NUMW'(smp_r[c]) +
                 ocmc_pkg::NUMW'(32'(win_r.mass) * 32'(st[win_r.slot].center[c]));
    ocmc_div_lane u_lane (
      .clk  (clk),
      .load (lane_load),
      .step (lane_step),
      .num  (num),
      .den  (den),
      .quot (quot[c])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ocmc_pkg::ST_IDLE:  if (accept) state_nxt = in_tuser ? ocmc_pkg::ST_TICK : ocmc_pkg::ST_DIST;
      ocmc_pkg::ST_TICK:  state_nxt = ocmc_pkg::ST_FIN;
      ocmc_pkg::ST_DIST:  state_nxt = ocmc_pkg::ST_SCAN;
      ocmc_pkg::ST_SCAN:  if (cnt_r == 6'(ocmc_pkg::NCL - 1)) state_nxt = ocmc_pkg::ST_THR1;
      ocmc_pkg::ST_THR1:  state_nxt = ocmc_pkg::ST_THR2;
      ocmc_pkg::ST_THR2: begin
        if (!make_new)  state_nxt = ocmc_pkg::ST_PREP;
        else if (full)  state_nxt = ocmc_pkg::ST_FIN;
        else            state_nxt = ocmc_pkg::ST_APPLY;
      end
      ocmc_pkg::ST_PREP:  state_nxt = ocmc_pkg::ST_DIV;
      ocmc_pkg::ST_DIV:   if (cnt_r == 6'(ocmc_pkg::DIV_STEPS - 1)) state_nxt = ocmc_pkg::ST_APPLY;
      ocmc_pkg::ST_APPLY: state_nxt = ocmc_pkg::ST_FIN;
      ocmc_pkg::ST_FIN:   if (out_free) state_nxt = ocmc_pkg::ST_IDLE;
      default:            state_nxt = ocmc_pkg::ST_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    in_tready  = 1'b0;
    lane_load  = 1'b0;
    lane_step  = 1'b0;
    cnt_nxt    = '0;
    cmd        = '0;
    cmd.slot   = slot_r;
    cmd.reload = reload_r;
    cmd.cval   = upd_r ? quot : smp_r;
    case (state_r)
      ocmc_pkg::ST_IDLE:  in_tready = 1'b1;
      ocmc_pkg::ST_TICK:  cmd.tick = 1'b1;
      ocmc_pkg::ST_SCAN:  cnt_nxt = cnt_r + 1'b1;
      ocmc_pkg::ST_PREP:  lane_load = 1'b1;
      ocmc_pkg::ST_DIV: begin
        lane_step = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
      end
      ocmc_pkg::ST_APPLY: begin
        cmd.create = !upd_r;
        cmd.update = upd_r;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ocmc_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (state_r == ocmc_pkg::ST_FIN && out_free) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // item payload and result registers
  always_ff @(posedge clk) begin
    case (state_r)
      ocmc_pkg::ST_IDLE: begin
        if (accept) begin
          kind_r    <= in_tuser;
          for (int c = 0; c < ocmc_pkg::CH; c++) begin
            smp_r[c] <= {in_tdata[c*ocmc_pkg::SW +: ocmc_pkg::SW], {ocmc_pkg::FB{1'b0}}};
          end
          created_r <= 1'b0;
          dropped_r <= 1'b0;
          upd_r     <= 1'b0;
          slot_r    <= '0;
          removed_r <= '0;
        end
      end
      ocmc_pkg::ST_TICK: removed_r <= gone_cnt;
      ocmc_pkg::ST_THR1: begin
        win_r <= tok[ocmc_pkg::NCL-1];
        p0_r  <= thr_r * tok[ocmc_pkg::NCL-1].d[ocmc_pkg::DLO-1:0];
        p1_r  <= thr_r * tok[ocmc_pkg::NCL-1].d[ocmc_pkg::DW-1:ocmc_pkg::DLO];
      end
      ocmc_pkg::ST_THR2: begin
        if (make_new) begin
          created_r <= 1'b1;
          dropped_r <= full;
          slot_r    <= full ? '0 : free_slot;
        end else begin
          upd_r  <= 1'b1;
          slot_r <= win_r.slot;
        end
      end
      ocmc_pkg::ST_FIN: begin
        if (out_free) begin
          out_data_r <= {3'b000, live_cnt, removed_r, slot_r, dropped_r, created_r};
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a transaction closes the input until the item is finished
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("input accepted while an item is in progress");

  // a drop is always flagged as a needed creation
  a_drop_created: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[1]) |-> out_tdata[0])
    else $error("dropped result without created flag");

  // ticks never report a slot or a creation
  a_tick_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ocmc_pkg::ST_FIN && kind_r) |-> (!created_r && slot_r == '0))
    else $error("tick result carries sample fields");

  // no cell command outside of its own state
  a_cmd_states: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.tick || cmd.create || cmd.update) |->
      (state_r == ocmc_pkg::ST_TICK || state_r == ocmc_pkg::ST_APPLY))
    else $error("cell command issued in wrong state");

endmodule
`default_nettype wire

/* tb/testbench.sv */
// self-checking testbench for the center-of-mass clustering block
`timescale 1ns / 1ps
`default_nettype none
module testbench;

  // cluster table tracker and queue of expected results
  class cluster_scoreboard;
    bit              valid[ocmc_pkg::NCL];
    longint unsigned ctr[ocmc_pkg::NCL][ocmc_pkg::CH];
    longint unsigned mass[ocmc_pkg::NCL];
    int unsigned     timer[ocmc_pkg::NCL];
    int unsigned     rank[ocmc_pkg::NCL];
    int unsigned     reload;
    bit [31:0]       thr;
    bit [15:0]       expected_q[$];
    int              errors;

    function new();
      reload = 100;
      thr    = 32'd65536;
      errors = 0;
      foreach (valid[k]) valid[k] = 0;
    endfunction

    function void configure(logic idx, bit [31:0] v);
      if (idx == ocmc_pkg::CFG_TIMER) reload = {16'd0, v[15:0]};
      else thr = v;
    endfunction

    // work out the result of one accepted transaction
    function void note_item(bit kind, bit [31:0] data);
      longint unsigned s[ocmc_pkg::CH];
      longint unsigned d, bd, diff, lhs, rhs;
      logic [127:0]    wl, wr;
      int unsigned     old_rank[ocmc_pkg::NCL];
      int              best, free_slot, n;
      bit              created, dropped, make_new;
      bit [2:0]        slot;
      int unsigned     removed, live;
      created = 0; dropped = 0; slot = 0; removed = 0; best = -1; bd = 0;
      if (kind) begin
        // aging tick
        for (int k = 0; k < ocmc_pkg::NCL; k++) begin
          old_rank[k] = rank[k];
          if (valid[k]) begin
            if (timer[k] == 0) begin
              valid[k] = 0;
              removed++;
            end else timer[k]--;
          end
        end
        for (int k = 0; k < ocmc_pkg::NCL; k++) begin
          if (valid[k]) begin
            n = 0;
            for (int j = 0; j < ocmc_pkg::NCL; j++)
              if (valid[j] && old_rank[j] < old_rank[k]) n++;
            rank[k] = n;
          end
        end
      end else begin
        for (int c = 0; c < ocmc_pkg::CH; c++) s[c] = longint'(data[8*c +: 8]) << ocmc_pkg::FB;
        // strongest cluster, ties to the newest
        for (int k = 0; k < ocmc_pkg::NCL; k++) begin
          if (valid[k]) begin
            d = ocmc_pkg::EPS;
            for (int c = 0; c < ocmc_pkg::CH; c++) begin
              diff = (s[c] >= ctr[k][c]) ? s[c] - ctr[k][c] : ctr[k][c] - s[c];
              d += diff * diff;
            end
            if (best < 0) begin
              best = k; bd = d;
            end else begin
              lhs = mass[k] * bd;
              rhs = mass[best] * d;
              if (lhs > rhs || (lhs == rhs && rank[k] < rank[best])) begin
                best = k; bd = d;
              end
            end
          end
        end
        if (best < 0) make_new = 1;
        else begin
          wl = 128'(mass[best]) << 32;
          wr = 128'(thr) * 128'(bd);
          make_new = wl < wr;
        end
        if (make_new) begin
          created = 1;
          free_slot = -1;
          for (int k = ocmc_pkg::NCL - 1; k >= 0; k--) if (!valid[k]) free_slot = k;
          if (free_slot < 0) dropped = 1;
          else begin
            for (int k = 0; k < ocmc_pkg::NCL; k++) if (valid[k]) rank[k]++;
            valid[free_slot] = 1;
            for (int c = 0; c < ocmc_pkg::CH; c++) ctr[free_slot][c] = s[c];
            mass[free_slot]  = 1;
            timer[free_slot] = reload;
            rank[free_slot]  = 0;
            slot = free_slot[2:0];
          end
        end else begin
          for (int c = 0; c < ocmc_pkg::CH; c++)
            ctr[best][c] = (s[c] + mass[best] * ctr[best][c]) / (mass[best] + 1);
          if (mass[best] < 65535) mass[best]++;
          timer[best] = reload;
          slot = best[2:0];
        end
      end
      live = 0;
      for (int k = 0; k < ocmc_pkg::NCL; k++) if (valid[k]) live++;
      expected_q.push_back({3'b0, live[3:0], removed[3:0], slot, dropped, created});
    endfunction

    // compare one result transaction against the oldest expectation
    function void check_result(bit [15:0] got);
      bit [15:0] exp_r;
      if (expected_q.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got[0] !== exp_r[0]) begin
        $error("created: expected %0d actual %0d", exp_r[0], got[0]); errors++;
      end
      if (got[1] !== exp_r[1]) begin
        $error("dropped: expected %0d actual %0d", exp_r[1], got[1]); errors++;
      end
      if (got[4:2] !== exp_r[4:2]) begin
        $error("winner_slot: expected %0d actual %0d", exp_r[4:2], got[4:2]); errors++;
      end
      if (got[8:5] !== exp_r[8:5]) begin
        $error("removed_count: expected %0d actual %0d", exp_r[8:5], got[8:5]); errors++;
      end
      if (got[12:9] !== exp_r[12:9]) begin
        $error("live_count: expected %0d actual %0d", exp_r[12:9], got[12:9]); errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // sample_ch0, sample_ch1, sample_ch2, sample_ch3
  logic        in_tuser = 0;    // kind
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [15:0] out_tdata;       // created, dropped, winner_slot, removed_count, live_count
  logic        cfg_we = 0;
  logic        cfg_index = 0;
  logic [31:0] cfg_wdata = '0;

  cluster_scoreboard sb = new();
  int          hold_cycles = 0;
  int          burst_left = 0;
  longint      cycle_count = 0;
  bit [31:0]   centers[ocmc_pkg::NCL];

  online_center_of_mass_clustering dut (.*);

  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver stall pattern and long hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_tready  <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      case (cycle_count[9:7])
        3'd0, 3'd1: out_tready <= 1'b1;
        3'd2:       out_tready <= ($urandom_range(3) == 0);
        default:    out_tready <= ($urandom_range(1) == 0);
      endcase
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // offer one transaction and wait for acceptance, with bursty gaps
  task automatic send_item(bit kind, bit [31:0] data);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    sb.note_item(kind, data);
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(12);
      if ($urandom_range(1)) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  endtask

  // drain all results, then let the block settle before a register write
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, bit [31:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.configure(idx, v);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // sample near one of a few centers, or anywhere
  function automatic bit [31:0] pick_sample();
    bit [31:0] v;
    bit [7:0]  b;
    if ($urandom_range(9) < 7) begin
      v = centers[$urandom_range(ocmc_pkg::NCL - 1)];
      for (int c = 0; c < ocmc_pkg::CH; c++) begin
        b = v[8*c +: 8];
        case ($urandom_range(3))
          0: if (b != 8'hFF) b++;
          1: if (b != 8'h00) b--;
          default: ;
        endcase
        v[8*c +: 8] = b;
      end
      return v;
    end
    return $urandom();
  endfunction

  task automatic random_phase(bit [15:0] reload, bit [31:0] thr_v, int n, int tick_pct);
    wait_drained();
    write_reg(ocmc_pkg::CFG_TIMER, {16'd0, reload});
    write_reg(ocmc_pkg::CFG_THR, thr_v);
    for (int k = 0; k < ocmc_pkg::NCL; k++) centers[k] = $urandom();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < tick_pct) send_item(1'b1, $urandom());
      else send_item(1'b0, pick_sample());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: defaults, extremes, empty tick, fill, drop, tie
    write_reg(ocmc_pkg::CFG_TIMER, 32'd100);
    write_reg(ocmc_pkg::CFG_THR, 32'd65536);
    send_item(1'b1, 32'h0);
    send_item(1'b0, 32'h00000000);
    send_item(1'b0, 32'hFFFFFFFF);
    send_item(1'b0, 32'h00000000);
    send_item(1'b0, 32'hFFFFFFFE);
    send_item(1'b1, 32'hFFFFFFFF);
    wait_drained();
    write_reg(ocmc_pkg::CFG_THR, 32'hFFFFFFFF);
    for (int i = 0; i < 7; i++) send_item(1'b0, 32'h80808080);
    send_item(1'b0, 32'h12345678);
    wait_drained();
    write_reg(ocmc_pkg::CFG_THR, 32'd0);
    send_item(1'b0, 32'h80808080);
    send_item(1'b0, 32'h00FF00FF);
    wait_drained();
    write_reg(ocmc_pkg::CFG_TIMER, 32'd0);
    write_reg(ocmc_pkg::CFG_THR, 32'd65536);
    send_item(1'b0, 32'hA5A5A5A5);
    send_item(1'b1, 32'h0);
    send_item(1'b1, 32'h0);

    // long receiver hold-off while the sender keeps offering
    wait_drained();
    hold_cycles = 400;
    for (int i = 0; i < 6; i++) send_item(1'b0, $urandom());

    // random phases over several register settings
    random_phase(16'd5, 32'd65536, 220, 20);
    random_phase(16'd0, 32'd0, 150, 15);
    random_phase(16'd65535, 32'hFFFFFFFF, 150, 10);
    random_phase(16'd40, 32'd16384, 200, 15);
    random_phase(16'd3, 32'd1 << 20, 180, 25);
    random_phase(16'd100, 32'd65536, 150, 10);

    wait_drained();
    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire

/* sim.f */
hw/rtl/ocmc_pkg.sv
hw/rtl/ocmc_cell.sv
hw/rtl/ocmc_div_lane.sv
hw/rtl/online_center_of_mass_clustering.sv
tb/testbench.sv
